@@ hdl/tsr_pkg.sv @@
// shared constants and types of the triangle span rasterizer
package tsr_pkg;

  localparam int unsigned COORD_BITS_DEF    = 13;
  localparam int unsigned SCREEN_HEIGHT_DEF = 256;
  localparam int unsigned ROW_BITS          = 8;
  localparam int unsigned OP_BITS           = 2;

  typedef enum logic [OP_BITS-1:0] {
    OP_CLEAR = 2'd0,
    OP_EDGE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  // commands from the sequencer to the line stepper
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctrl_t;

  // line stepper status back to the sequencer
  typedef struct packed {
    logic run;
    logic last;
  } walk_stat_t;

endpackage

@@ hdl/tsr_table.sv @@
// contour table memory: one write port, one read port with registered data
module tsr_table #(
  parameter int unsigned Depth = tsr_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned DataW = 2 * tsr_pkg::COORD_BITS_DEF,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/tsr_walker.sv @@
// bresenham line stepper: one shared accumulator add and compare per step
module tsr_walker #(
  parameter int unsigned COORD_BITS = tsr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsr_pkg::walk_ctrl_t          ctrl_i,
  input  logic signed [COORD_BITS-1:0] x_start_i,
  input  logic signed [COORD_BITS-1:0] y_start_i,
  input  logic signed [COORD_BITS-1:0] x_end_i,
  input  logic signed [COORD_BITS-1:0] y_end_i,
  output logic signed [COORD_BITS-1:0] x_o,
  output logic signed [COORD_BITS-1:0] y_o,
  output tsr_pkg::walk_stat_t          stat_o
);

  localparam int unsigned CW = COORD_BITS;

  typedef enum logic [1:0] {
    W_IDLE,
    W_INIT,
    W_RUN
  } phase_e;

  phase_e                 phase_q;
  logic signed [CW-1:0]   x_q, y_q;
  logic signed [CW:0]     dx_q, dy_q;
  logic [CW-1:0]          major_q, minor_q;
  logic [CW:0]            acc_q, count_q;
  logic signed [1:0]      diag_x_q, diag_y_q, side_x_q, side_y_q;

  logic signed [CW:0]     dx_d, dy_d, adx_s, ady_s;
  logic [CW-1:0]          adx, ady;
  logic                   swap;
  logic signed [1:0]      sgn_x, sgn_y;
  logic [CW:0]            sum;
  logic                   take_side;
  logic signed [1:0]      inc_x, inc_y;

  assign dx_d = {x_end_i[CW-1], x_end_i} - {x_start_i[CW-1], x_start_i};
  assign dy_d = {y_end_i[CW-1], y_end_i} - {y_start_i[CW-1], y_start_i};

  assign adx_s = dx_q[CW] ? -dx_q : dx_q;
  assign ady_s = dy_q[CW] ? -dy_q : dy_q;
  assign adx   = adx_s[CW-1:0];
  assign ady   = ady_s[CW-1:0];
  assign swap  = adx < ady;
  assign sgn_x = dx_q[CW] ? 2'sb11 : ((dx_q != '0) ? 2'sb01 : 2'sb00);
  assign sgn_y = dy_q[CW] ? 2'sb11 : ((dy_q != '0) ? 2'sb01 : 2'sb00);

  // error accumulator: the one add and compare shared by every step
  assign sum       = acc_q + {1'b0, minor_q};
  assign take_side = sum < {1'b0, major_q};
  assign inc_x     = take_side ? side_x_q : diag_x_q;
  assign inc_y     = take_side ? side_y_q : diag_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= W_IDLE;
      x_q      <= '0;
      y_q      <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      major_q  <= '0;
      minor_q  <= '0;
      acc_q    <= '0;
      count_q  <= '0;
      diag_x_q <= '0;
      diag_y_q <= '0;
      side_x_q <= '0;
      side_y_q <= '0;
    end else begin
      unique case (phase_q)
        W_IDLE: begin
          if (ctrl_i.start) begin
            x_q     <= x_start_i;
            y_q     <= y_start_i;
            dx_q    <= dx_d;
            dy_q    <= dy_d;
            phase_q <= W_INIT;
          end
        end
        W_INIT: begin
          major_q  <= swap ? ady : adx;
          minor_q  <= swap ? adx : ady;
          acc_q    <= {2'b00, (swap ? adx[CW-1:1] : ady[CW-1:1])};
          count_q  <= {1'b0, (swap ? ady : adx)} + (CW+1)'(1);
          diag_x_q <= sgn_x;
          diag_y_q <= sgn_y;
          side_x_q <= swap ? 2'sb00 : sgn_x;
          side_y_q <= swap ? sgn_y : 2'sb00;
          phase_q  <= W_RUN;
        end
        W_RUN: begin
          if (ctrl_i.step) begin
            acc_q   <= take_side ? sum : (sum - {1'b0, major_q});
            x_q     <= x_q + {{(CW-2){inc_x[1]}}, inc_x};
            y_q     <= y_q + {{(CW-2){inc_y[1]}}, inc_y};
            count_q <= count_q - (CW+1)'(1);
            if (count_q == (CW+1)'(1)) begin
              phase_q <= W_IDLE;
            end
          end
        end
        default: begin
          phase_q <= W_IDLE;
        end
      endcase
    end
  end

  assign x_o         = x_q;
  assign y_o         = y_q;
  assign stat_o.run  = (phase_q == W_RUN);
  assign stat_o.last = (count_q == (CW+1)'(1));

endmodule

@@ hdl/triangle_span_rasterizer.sv @@
// top level: sequencer over the contour table and the line stepper
//
// Input channel (in_valid_i/in_ready_o) takes one item per transfer:
//   clear  - empties every row, no result
//   edge   - walks the line between the two endpoints and widens the
//            bounds of each on-screen row it visits, no result;
//            after a setup state in the stepper, each on-screen step
//            reads memory, then merges and writes, and each off-screen
//            step skips the memory, with max(|dx|,|dy|)+1 steps
//   query  - one result on the output channel; the result register is
//            loaded in the query read state once it is free
//   opcode 3 is dropped with no effect
// in_ready_o is high only while the sequencer is idle; one item at a time.
// The output channel (out_valid_o/out_ready_i) has its own result register,
// so clear and edge items go ahead while a result waits; a query waits for
// that register to be taken before it loads the next result.
// After reset the block runs a clearing pass over every row of the table
// with in_ready_o low.
module triangle_span_rasterizer #(
  parameter int unsigned COORD_BITS    = tsr_pkg::COORD_BITS_DEF,
  parameter int unsigned SCREEN_HEIGHT = tsr_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tsr_pkg::OP_BITS-1:0]      opcode_i,
  input  logic signed [COORD_BITS-1:0]     edge_x_start_i,
  input  logic signed [COORD_BITS-1:0]     edge_y_start_i,
  input  logic signed [COORD_BITS-1:0]     edge_x_end_i,
  input  logic signed [COORD_BITS-1:0]     edge_y_end_i,
  input  logic [tsr_pkg::ROW_BITS-1:0]     query_row_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             span_valid_o,
  output logic signed [COORD_BITS-1:0]     span_left_o,
  output logic signed [COORD_BITS-1:0]     span_right_o,
  output logic [tsr_pkg::ROW_BITS-1:0]     span_row_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned AW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int unsigned YW = (CW > AW + 1) ? CW : AW + 1;
  localparam int unsigned RB = tsr_pkg::ROW_BITS;
  localparam int unsigned QW = (RB > AW + 1) ? RB : AW + 1;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic [AW-1:0]        LAST_ROW  = AW'(SCREEN_HEIGHT - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRD,
    S_WWR,
    S_QRD
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        clr_idx_q;
  logic [RB-1:0]        qrow_q;
  logic                 qon_q;
  logic                 out_valid_q;
  logic                 span_valid_q;
  logic signed [CW-1:0] span_left_q, span_right_q;
  logic [RB-1:0]        span_row_q;

  tsr_pkg::walk_ctrl_t  wctrl;
  tsr_pkg::walk_stat_t  wstat;
  logic signed [CW-1:0] wx, wy;

  logic                 tbl_wr_en, tbl_rd_en;
  logic [AW-1:0]        tbl_wr_addr, tbl_rd_addr;
  logic [2*CW-1:0]      tbl_wr_data, tbl_rd_data;

  logic                 in_xfer, out_free, out_load;
  logic [YW-1:0]        y_ext;
  logic                 y_on;
  logic [QW-1:0]        q_ext;
  logic                 q_on;
  logic signed [CW-1:0] old_left, old_right, new_left, new_right;
  logic                 row_has_span;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = (state_q == S_QRD) && out_free;

  // row range checks, widened so the screen height always fits
  assign y_ext = YW'($unsigned(wy));
  assign y_on  = !wy[CW-1] && (y_ext < YW'(SCREEN_HEIGHT));
  assign q_ext = QW'(query_row_i);
  assign q_on  = q_ext < QW'(SCREEN_HEIGHT);

  assign old_left     = tbl_rd_data[2*CW-1:CW];
  assign old_right    = tbl_rd_data[CW-1:0];
  assign new_left     = (wx < old_left) ? wx : old_left;
  assign new_right    = (wx > old_right) ? wx : old_right;
  assign row_has_span = qon_q && (old_right >= old_left);

  always_comb begin
    wctrl       = '0;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = clr_idx_q;
    tbl_wr_data = {COORD_MAX, COORD_MIN};
    tbl_rd_en   = 1'b0;
    tbl_rd_addr = y_ext[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        tbl_wr_en = 1'b1;
      end
      S_IDLE: begin
        wctrl.start = in_xfer && (opcode_i == tsr_pkg::OP_EDGE);
        tbl_rd_en   = in_xfer && (opcode_i == tsr_pkg::OP_QUERY) && q_on;
        tbl_rd_addr = q_ext[AW-1:0];
      end
      S_WRD: begin
        tbl_rd_en  = wstat.run && y_on;
        wctrl.step = wstat.run && !y_on;
      end
      S_WWR: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = y_ext[AW-1:0];
        tbl_wr_data = {new_left, new_right};
        wctrl.step  = 1'b1;
      end
      S_QRD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_idx_q    <= '0;
      qrow_q       <= '0;
      qon_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      span_valid_q <= 1'b0;
      span_left_q  <= '0;
      span_right_q <= '0;
      span_row_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (clr_idx_q == LAST_ROW) begin
            clr_idx_q <= '0;
            state_q   <= S_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            unique case (opcode_i)
              tsr_pkg::OP_CLEAR: state_q <= S_CLEAR;
              tsr_pkg::OP_EDGE:  state_q <= S_WRD;
              tsr_pkg::OP_QUERY: begin
                qrow_q  <= query_row_i;
                qon_q   <= q_on;
                state_q <= S_QRD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_WRD: begin
          if (wstat.run) begin
            if (y_on) begin
              state_q <= S_WWR;
            end else if (wstat.last) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_WWR: begin
          state_q <= wstat.last ? S_IDLE : S_WRD;
        end
        S_QRD: begin
          if (out_load) begin
            span_valid_q <= row_has_span;
            span_left_q  <= row_has_span ? old_left : '0;
            span_right_q <= row_has_span ? old_right : '0;
            span_row_q   <= qrow_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  tsr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_tsr_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (wctrl),
    .x_start_i (edge_x_start_i),
    .y_start_i (edge_y_start_i),
    .x_end_i   (edge_x_end_i),
    .y_end_i   (edge_y_end_i),
    .x_o       (wx),
    .y_o       (wy),
    .stat_o    (wstat)
  );

  tsr_table #(
    .Depth (SCREEN_HEIGHT),
    .DataW (2 * COORD_BITS)
  ) u_tsr_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_en_i   (tbl_rd_en),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (tbl_rd_data)
  );

  assign out_valid_o  = out_valid_q;
  assign span_valid_o = span_valid_q;
  assign span_left_o  = span_left_q;
  assign span_right_o = span_right_q;
  assign span_row_o   = span_row_q;

endmodule

@@ hdl/tsr_checker.sv @@
// port-level checks for the triangle span rasterizer, bound to the top level
module tsr_checker #(
  parameter int unsigned COORD_BITS = tsr_pkg::COORD_BITS_DEF
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [tsr_pkg::OP_BITS-1:0]  opcode_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         span_valid_o,
  input logic signed [COORD_BITS-1:0] span_left_o,
  input logic signed [COORD_BITS-1:0] span_right_o,
  input logic [tsr_pkg::ROW_BITS-1:0] span_row_o
);

  // clearing pass runs right after reset
  a_busy_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input ready during the clearing pass after reset");

  // a clear transfer starts a sweep that holds off the next item
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (opcode_i == tsr_pkg::OP_CLEAR)) |=> !in_ready_o)
    else $error("input ready right after a clear transfer");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && span_valid_o) |-> (span_left_o <= span_right_o))
    else $error("valid span with left bound past right bound");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !span_valid_o) |-> (span_left_o == '0 && span_right_o == '0))
    else $error("empty span with nonzero bounds");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(span_valid_o) &&
      $stable(span_left_o) && $stable(span_right_o) && $stable(span_row_o)))
    else $error("stalled result changed");

endmodule

bind triangle_span_rasterizer tsr_checker #(
  .COORD_BITS (COORD_BITS)
) u_tsr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .span_valid_o (span_valid_o),
  .span_left_o  (span_left_o),
  .span_right_o (span_right_o),
  .span_row_o   (span_row_o)
);

@@ test/tb.sv @@
// testbench for triangle_span_rasterizer: random triangles against a contour-table predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW         = tsr_pkg::COORD_BITS_DEF;
  localparam int SCREEN_H   = tsr_pkg::SCREEN_HEIGHT_DEF;
  localparam int RB         = tsr_pkg::ROW_BITS;
  localparam int COORD_MAX  = 2 ** (CW - 1) - 1;
  localparam int COORD_MIN  = -(2 ** (CW - 1));
  localparam int ITEM_GOAL  = 1050;
  localparam int IDLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    tsr_pkg::opcode_e      op;
    logic signed [CW-1:0]  xs;
    logic signed [CW-1:0]  ys;
    logic signed [CW-1:0]  xe;
    logic signed [CW-1:0]  ye;
    logic [RB-1:0]         row;
  } raster_cmd_t;

  typedef struct {
    logic                  valid;
    logic signed [CW-1:0]  left;
    logic signed [CW-1:0]  right;
    logic [RB-1:0]         row;
  } span_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_ready_o;
  logic [tsr_pkg::OP_BITS-1:0] opcode_i = tsr_pkg::OP_NOP;
  logic signed [CW-1:0]        edge_x_start_i = '0;
  logic signed [CW-1:0]        edge_y_start_i = '0;
  logic signed [CW-1:0]        edge_x_end_i = '0;
  logic signed [CW-1:0]        edge_y_end_i = '0;
  logic [RB-1:0]               query_row_i = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        span_valid_o;
  logic signed [CW-1:0]        span_left_o;
  logic signed [CW-1:0]        span_right_o;
  logic [RB-1:0]               span_row_o;

  raster_cmd_t raster_cmds[$];
  span_t       pending_spans[$];
  raster_cmd_t drv_cmd;
  span_t       want;
  int          row_lo[SCREEN_H];
  int          row_hi[SCREEN_H];
  int          cmd_cnt = 0;
  int          mismatch_cnt = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;

  triangle_span_rasterizer u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .edge_x_start_i (edge_x_start_i),
    .edge_y_start_i (edge_y_start_i),
    .edge_x_end_i   (edge_x_end_i),
    .edge_y_end_i   (edge_y_end_i),
    .query_row_i    (query_row_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .span_valid_o   (span_valid_o),
    .span_left_o    (span_left_o),
    .span_right_o   (span_right_o),
    .span_row_o     (span_row_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // contour table model

  function automatic void clear_contour();
    for (int i = 0; i < SCREEN_H; i++) begin
      row_lo[i] = COORD_MAX;
      row_hi[i] = COORD_MIN;
    end
  endfunction

  function automatic void trace_edge(input int xa, input int ya, input int xb, input int yb);
    int dx, dy, sx, sy, major, minor, side_x, side_y, x, y, acc, tmp;
    dx = xb - xa;
    dy = yb - ya;
    sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
    sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    major = (dx < 0) ? -dx : dx;
    minor = (dy < 0) ? -dy : dy;
    side_x = sx;
    side_y = 0;
    if (major < minor) begin
      tmp = major;
      major = minor;
      minor = tmp;
      side_x = 0;
      side_y = sy;
    end
    x = xa;
    y = ya;
    acc = minor / 2;
    for (int n = major + 1; n > 0; n--) begin
      if (y >= 0 && y < SCREEN_H) begin
        if (x < row_lo[y]) row_lo[y] = x;
        if (x > row_hi[y]) row_hi[y] = x;
      end
      acc += minor;
      // minor-axis step only once the error term wraps
      if (acc < major) begin
        x += side_x;
        y += side_y;
      end else begin
        acc -= major;
        x += sx;
        y += sy;
      end
    end
  endfunction

  function automatic span_t lookup_span(input logic [RB-1:0] row);
    span_t s;
    s.valid = 1'b0;
    s.left  = '0;
    s.right = '0;
    s.row   = row;
    if (int'(row) < SCREEN_H && row_hi[row] >= row_lo[row]) begin
      s.valid = 1'b1;
      s.left  = CW'(row_lo[row]);
      s.right = CW'(row_hi[row]);
    end
    return s;
  endfunction

  // stimulus helpers

  function automatic logic signed [CW-1:0] any_coord();
    return CW'($urandom_range(0, 2 ** CW - 1));
  endfunction

  // mostly near the screen, now and then the extremes
  function automatic int pick_coord(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return COORD_MIN;
    if (r == 1) return COORD_MAX;
    if (r == 2) return int'(any_coord());
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic raster_cmd_t noise_cmd(input tsr_pkg::opcode_e op);
    raster_cmd_t c;
    c.op  = op;
    c.xs  = any_coord();
    c.ys  = any_coord();
    c.xe  = any_coord();
    c.ye  = any_coord();
    c.row = RB'($urandom_range(0, 2 ** RB - 1));
    return c;
  endfunction

  function automatic void add_clear();
    raster_cmds.insert(raster_cmds.size(), noise_cmd(tsr_pkg::OP_CLEAR));
    cmd_cnt++;
  endfunction

  function automatic void add_nop();
    raster_cmds.insert(raster_cmds.size(), noise_cmd(tsr_pkg::OP_NOP));
  endfunction

  function automatic void add_edge(input int xa, input int ya, input int xb, input int yb);
    raster_cmd_t c;
    c = noise_cmd(tsr_pkg::OP_EDGE);
    c.xs = CW'(xa);
    c.ys = CW'(ya);
    c.xe = CW'(xb);
    c.ye = CW'(yb);
    raster_cmds.insert(raster_cmds.size(), c);
    cmd_cnt++;
  endfunction

  function automatic void add_query(input int row);
    raster_cmd_t c;
    c = noise_cmd(tsr_pkg::OP_QUERY);
    c.row = RB'(row);
    raster_cmds.insert(raster_cmds.size(), c);
    cmd_cnt++;
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (raster_cmds.size() > 0) begin
        drv_cmd = raster_cmds.pop_front();
        opcode_i       <= drv_cmd.op;
        edge_x_start_i <= drv_cmd.xs;
        edge_y_start_i <= drv_cmd.ys;
        edge_x_end_i   <= drv_cmd.xe;
        edge_y_end_i   <= drv_cmd.ye;
        query_row_i    <= drv_cmd.row;
        in_valid_i     <= 1'b1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: always ready, mostly ready, or mostly stalled, switching now and then
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(32, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 9) < 7);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // predict at each input transfer
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (opcode_i)
        tsr_pkg::OP_CLEAR: clear_contour();
        tsr_pkg::OP_EDGE:
          trace_edge(edge_x_start_i, edge_y_start_i, edge_x_end_i, edge_y_end_i);
        tsr_pkg::OP_QUERY:
          pending_spans.insert(pending_spans.size(), lookup_span(query_row_i));
        default: ;
      endcase
    end
  end

  // check each output transfer against the oldest predicted span
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected span transfer for row %0d", span_row_o);
        mismatch_cnt++;
      end else begin
        want = pending_spans.pop_front();
        if (span_valid_o !== want.valid) begin
          $error("span_valid: expected %0d, got %0d", want.valid, span_valid_o);
          mismatch_cnt++;
        end
        if (span_left_o !== want.left) begin
          $error("span_left: expected %0d, got %0d", want.left, span_left_o);
          mismatch_cnt++;
        end
        if (span_right_o !== want.right) begin
          $error("span_right: expected %0d, got %0d", want.right, span_right_o);
          mismatch_cnt++;
        end
        if (span_row_o !== want.row) begin
          $error("span_row: expected %0d, got %0d", want.row, span_row_o);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int r, nq, ylo, yhi;
    int vx[3];
    int vy[3];

    clear_contour();

    // empty rows after reset
    add_query(0);
    add_query(SCREEN_H - 1);
    // single point edge
    add_edge(10, 20, 10, 20);
    add_query(20);
    // full-width horizontal line
    add_edge(COORD_MIN, 5, COORD_MAX, 5);
    add_query(5);
    // full-height vertical line walked upward, most steps off screen
    add_edge(100, COORD_MAX, 100, COORD_MIN);
    add_query(0);
    add_query(SCREEN_H - 1);
    add_edge(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    add_query(128);
    // unused opcode must leave the table alone
    add_nop();
    add_query(128);
    add_clear();
    add_query(5);
    add_query(128);
    add_edge(40, 10, 200, 60);
    add_edge(200, 60, 90, 230);
    add_edge(90, 230, 40, 10);
    add_query(10);
    add_query(60);
    add_query(150);
    add_query(230);
    add_query(231);
    add_edge(-30, 250, 5, -40);
    add_query(100);

    while (cmd_cnt < ITEM_GOAL - 1) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        if ($urandom_range(0, 2) != 0) add_clear();
        for (int i = 0; i < 3; i++) begin
          vx[i] = pick_coord(-64, 319);
          vy[i] = pick_coord(-32, 287);
        end
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(0, 1) == 0) add_edge(vx[i], vy[i], vx[(i+1)%3], vy[(i+1)%3]);
          else add_edge(vx[(i+1)%3], vy[(i+1)%3], vx[i], vy[i]);
        end
        ylo = vy[0];
        yhi = vy[0];
        for (int i = 1; i < 3; i++) begin
          if (vy[i] < ylo) ylo = vy[i];
          if (vy[i] > yhi) yhi = vy[i];
        end
        if (ylo < 0) ylo = 0;
        if (yhi > SCREEN_H - 1) yhi = SCREEN_H - 1;
        nq = $urandom_range(2, 8);
        for (int i = 0; i < nq; i++) begin
          if (ylo <= yhi && $urandom_range(0, 4) != 0) add_query(ylo + $urandom_range(0, yhi - ylo));
          else add_query($urandom_range(0, SCREEN_H - 1));
        end
      end else if (r < 80) begin
        add_edge(pick_coord(-64, 319), pick_coord(-32, 287),
                 pick_coord(-64, 319), pick_coord(-32, 287));
      end else if (r < 88) begin
        add_nop();
      end else if (r < 95) begin
        add_query($urandom_range(0, SCREEN_H - 1));
      end else begin
        add_clear();
      end
    end
    // a closing query makes sure every edge has been walked
    add_query($urandom_range(0, SCREEN_H - 1));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (raster_cmds.size() != 0 || in_valid_i || pending_spans.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
